// ===== rtl/bpfa_pkg.sv =====
// shared types, codes and helper functions of the bitmap page frame allocator
`default_nettype none
package bpfa_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned WORD_BITS = 32;
    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hffff_ffff;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_MISALIGN = 2'd2,
        STAT_NOT_USED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_MOD,
        S_OUT
    } t_state;

    // index of the lowest zero bit, only meaningful when the word is not full
    function automatic logic [4:0] lowest_clear(input logic [WORD_BITS-1:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bpfa_in_if.sv =====
// request channel: action, address and range end with valid/ready
`default_nettype none
interface bpfa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] range_end;

    modport source (output valid, output action, output address, output range_end,
                    input ready);
    modport sink   (input valid, input action, input address, input range_end,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/bpfa_out_if.sv =====
// result channel: frame address and status with valid/ready
`default_nettype none
interface bpfa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_address;
    logic [1:0]  status;

    modport source (output valid, output frame_address, output status, input ready);
    modport sink   (input valid, input frame_address, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/bpfa_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none
module bpfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32768
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator_unit.sv =====
// Bitmap page frame allocator: one bit per frame, 1 = used.
// Requests arrive on i_in (action, address, range_end) and each gives exactly
// one result on o_out (frame_address, status), both valid/ready channels.
// The bitmap lives in one ram of USABLE_WORDS x 32 bits with a registered read;
// every word touched passes through S_RD (read) and S_MOD (modify/write).
// A free reads the word that holds its frame and clears the bit if it is set;
// an allocate scans words from the hint up to the first one with a clear bit;
// a toggle visits each bitmap word the range spans; a rejected free, an empty
// toggle, a none and an allocate on a full bitmap go straight to the result.
// A hint register marks the first word that may hold a clear bit, so an
// allocate usually reads one word; a fully used bitmap answers without a read.
// One request is worked at a time; the next is accepted as soon as the block
// is back in idle, even while the previous result waits on o_out.
// After reset a clearing pass writes all ones to every word, one word per
// cycle (USABLE_WORDS words, 32768 at the defaults); i_in.ready stays low
// until it ends. When the receiver stalls, the result holds in the output
// register and a finished later request waits until that register empties.
`default_nettype none
module bitmap_page_frame_allocator_unit #(
    parameter int unsigned BITMAP_WORDS = 32768,
    parameter int unsigned FRAME_SHIFT  = 12
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpfa_in_if.sink    i_in,
    bpfa_out_if.source o_out
);
    import bpfa_pkg::*;

    localparam int unsigned ADDR_WORDS   = 1 << (27 - FRAME_SHIFT);
    localparam int unsigned USABLE_WORDS =
        (BITMAP_WORDS < ADDR_WORDS) ? BITMAP_WORDS : ADDR_WORDS;
    localparam int unsigned WAW   = (USABLE_WORDS > 1) ? $clog2(USABLE_WORDS) : 1;
    localparam int unsigned WCW   = $clog2(USABLE_WORDS + 1);
    localparam int unsigned FIW   = ADDR_W - FRAME_SHIFT;       // frame index from address
    localparam int unsigned F1W   = ADDR_W + 1 - FRAME_SHIFT;   // rounded-up end frame
    localparam int unsigned WIDX  = FIW - 5;
    localparam int unsigned LIMIT = USABLE_WORDS * WORD_BITS;
    localparam logic [WCW-1:0] WORDS_C = WCW'(USABLE_WORDS);
    localparam logic [F1W-1:0] LIMIT_F = F1W'(LIMIT);
    localparam logic [ADDR_W:0] SIZE_M1 = (ADDR_W+1)'((1 << FRAME_SHIFT) - 1);

    t_state r_state, n_state;
    t_action r_act, n_act;
    logic [WAW-1:0] r_clr, n_clr;
    logic [WCW-1:0] r_hint, n_hint;
    logic [WCW-1:0] r_w, n_w;
    logic [WCW-1:0] r_wlast, n_wlast;
    logic [4:0] r_lo, n_lo;
    logic [4:0] r_hib, n_hib;
    logic [4:0] r_bit, n_bit;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    t_status r_res_stat, n_res_stat;
    logic r_ovalid, n_ovalid;
    logic [ADDR_W-1:0] r_oaddr, n_oaddr;
    t_status r_ostat, n_ostat;

    logic mem_we, mem_re;
    logic [WAW-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

    // request decode
    logic accept;
    t_action in_act;
    logic misal;
    logic [FIW-1:0] frm;
    logic [WIDX-1:0] in_word;
    logic in_word_ok;
    logic [F1W-1:0] f0, f1, f1m;
    logic [ADDR_W:0] end_sum;
    logic tog_empty;

    // word modify
    logic word_full;
    logic [4:0] bsel;
    logic [WCW-1:0] w_inc;
    logic scan_end;
    logic tog_last;
    logic [WORD_BITS-1:0] tmask, tword;
    logic out_free;

    assign accept     = i_in.valid && i_in.ready;
    assign in_act     = t_action'(i_in.action);
    assign misal      = |i_in.address[FRAME_SHIFT-1:0];
    assign frm        = i_in.address[ADDR_W-1:FRAME_SHIFT];
    assign in_word    = frm[FIW-1:5];
    assign in_word_ok = 32'(in_word) < 32'(USABLE_WORDS);
    assign f0         = F1W'(frm);
    assign end_sum    = {1'b0, i_in.range_end} + SIZE_M1;
    assign f1         = (end_sum[ADDR_W:FRAME_SHIFT] > LIMIT_F) ? LIMIT_F
                                                                  : end_sum[ADDR_W:FRAME_SHIFT];
    assign f1m        = f1 - F1W'(1);
    assign tog_empty  = f1 <= f0;

    assign word_full = mem_rdata == ALL_ONES;
    assign bsel      = lowest_clear(mem_rdata);
    assign w_inc     = r_w + WCW'(1);
    assign scan_end  = w_inc == WORDS_C;
    assign tog_last  = r_w == r_wlast;
    assign tmask     = (ALL_ONES << r_lo)
                     & (tog_last ? (ALL_ONES >> (5'd31 - r_hib)) : ALL_ONES);
    assign tword     = mem_rdata ^ tmask;
    assign out_free  = !r_ovalid || o_out.ready;

    bpfa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(USABLE_WORDS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(r_w[WAW-1:0]),
        .o_rdata(mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == WAW'(USABLE_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_act)
                        ACT_ALLOC:  n_state = (r_hint == WORDS_C) ? S_OUT : S_RD;
                        ACT_FREE:   n_state = (misal || !in_word_ok) ? S_OUT : S_RD;
                        ACT_TOGGLE: n_state = tog_empty ? S_OUT : S_RD;
                        ACT_NONE:   n_state = S_OUT;
                    endcase
                end
            end
            S_RD: n_state = S_MOD;
            S_MOD: begin
                unique case (r_act)
                    ACT_ALLOC:  n_state = (word_full && !scan_end) ? S_RD : S_OUT;
                    ACT_TOGGLE: n_state = tog_last ? S_OUT : S_RD;
                    ACT_FREE,
                    ACT_NONE:   n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_act      = r_act;
        n_clr      = r_clr;
        n_hint     = r_hint;
        n_w        = r_w;
        n_wlast    = r_wlast;
        n_lo       = r_lo;
        n_hib      = r_hib;
        n_bit      = r_bit;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        n_ovalid   = r_ovalid;
        n_oaddr    = r_oaddr;
        n_ostat    = r_ostat;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_w[WAW-1:0];
        mem_wdata  = mem_rdata;

        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = ALL_ONES;
                n_clr     = r_clr + WAW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_act      = in_act;
                    n_res_addr = '0;
                    n_res_stat = STAT_OK;
                    n_bit      = frm[4:0];
                    n_lo       = f0[4:0];
                    n_hib      = f1m[4:0];
                    n_wlast    = WCW'(f1m >> 5);
                    unique case (in_act)
                        ACT_ALLOC: begin
                            n_w = r_hint;
                            if (r_hint == WORDS_C) n_res_stat = STAT_FULL;
                        end
                        ACT_FREE: begin
                            n_w = WCW'(in_word);
                            if (misal)            n_res_stat = STAT_MISALIGN;
                            else if (!in_word_ok) n_res_stat = STAT_NOT_USED;
                        end
                        ACT_TOGGLE: n_w = WCW'(f0 >> 5);
                        ACT_NONE:   n_w = r_w;
                    endcase
                end
            end
            S_RD: mem_re = 1'b1;
            S_MOD: begin
                unique case (r_act)
                    ACT_ALLOC: begin
                        if (word_full) begin
                            n_w    = w_inc;
                            n_hint = w_inc;
                            if (scan_end) n_res_stat = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_wdata  = mem_rdata | (WORD_BITS'(1) << bsel);
                            n_res_addr = 32'({r_w, bsel}) << FRAME_SHIFT;
                            n_hint     = ((mem_rdata | (WORD_BITS'(1) << bsel)) == ALL_ONES)
                                       ? w_inc : r_w;
                        end
                    end
                    ACT_FREE: begin
                        if (!mem_rdata[r_bit]) begin
                            n_res_stat = STAT_NOT_USED;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~(WORD_BITS'(1) << r_bit);
                            if (r_w < r_hint) n_hint = r_w;
                        end
                    end
                    ACT_TOGGLE: begin
                        mem_we    = 1'b1;
                        mem_wdata = tword;
                        if (tword != ALL_ONES && r_w < r_hint) n_hint = r_w;
                        n_lo = '0;
                        n_w  = w_inc;
                    end
                    ACT_NONE: ;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_res_addr;
                    n_ostat  = r_res_stat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_hint   <= WORDS_C;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_hint   <= n_hint;
            r_ovalid <= n_ovalid;
        end
        r_act      <= n_act;
        r_w        <= n_w;
        r_wlast    <= n_wlast;
        r_lo       <= n_lo;
        r_hib      <= n_hib;
        r_bit      <= n_bit;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
        r_oaddr    <= n_oaddr;
        r_ostat    <= n_ostat;
    end

    assign i_in.ready          = r_state == S_IDLE;
    assign o_out.valid         = r_ovalid;
    assign o_out.frame_address = r_oaddr;
    assign o_out.status        = r_ostat;
endmodule
`default_nettype wire

// ===== rtl/bpfa_checker.sv =====
// port-level checks for the allocator and the bind that attaches them
`default_nettype none
module bpfa_checker #(
    parameter int unsigned FRAME_SHIFT = 12
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_addr,
    input wire logic [1:0]  i_out_status
);
    import bpfa_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_addr) && $stable(i_out_status))
        else $error("result changed while stalled");

    // the bitmap clearing pass keeps requests out right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("busy/valid wrong after reset");

    // an address is only returned by a good allocate and is frame aligned
    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_addr != 32'd0 |->
            i_out_status == STAT_OK && i_out_addr[FRAME_SHIFT-1:0] == '0)
        else $error("bad frame address in result");
endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker #(
    .FRAME_SHIFT(FRAME_SHIFT)
) u_bpfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_addr  (o_out.frame_address),
    .i_out_status(o_out.status)
);
`default_nettype wire
